// ----- rtl/core/b64le_pkg.sv -----
// Package for the line-wrapped base64 encoder: constants, types and the alphabet.
`timescale 1ns / 1ps
`default_nettype none
package b64le_pkg;

  // Line length in characters and the number of four-character groups per line
  localparam int LINE_CHARS      = 76;
  localparam int GROUPS_PER_LINE = LINE_CHARS / 4;
  localparam int GROUP_W         = $clog2(GROUPS_PER_LINE + 1);

  // Fixed characters
  localparam logic [7:0] CHAR_PAD = 8'd61;  // '='
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;

  // Byte position inside its three-byte group
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  // Encoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]         phase;
    logic [3:0]         leftover;
    logic [GROUP_W-1:0] groups;
  } b64le_state_t;

  // Characters produced by one input byte, first character in slot 0
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      cnt;
    logic            last;
  } b64le_burst_t;

  // Map a six-bit value to its base64 character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      return 8'd65 + v8;
    end else if (v < 6'd52) begin
      return 8'd97 + v8 - 8'd26;
    end else if (v < 6'd62) begin
      return 8'd48 + v8 - 8'd52;
    end else if (v == 6'd62) begin
      return 8'd43;
    end else begin
      return 8'd47;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/b64le_stream_if.sv -----
// Stream interfaces for the encoder: byte input channel and character output channel.
`timescale 1ns / 1ps
`default_nettype none
interface b64le_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64le_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/b64le_encode.sv -----
// Combinational encode of one byte: characters it releases and the next encoder state.
`timescale 1ns / 1ps
`default_nettype none
module b64le_encode
  import b64le_pkg::*;
(
  input  wire logic [7:0]   data_byte,
  input  wire logic         last_byte,
  input  wire b64le_state_t state_cur,
  output b64le_state_t      state_nxt,
  output b64le_burst_t      burst
);

  logic [GROUP_W-1:0] groups_inc;

  assign groups_inc = state_cur.groups + GROUP_W'(1);

  always_comb begin
    burst       = '0;
    burst.last  = last_byte;
    state_nxt   = state_cur;
    case (state_cur.phase)
      PHASE_SECOND: begin
        // Close the second sextet and keep four bits for the third, or pad the group on the last byte
        burst.chars[0]     = sextet_char({state_cur.leftover[1:0], data_byte[7:4]});
        burst.cnt          = 3'd1;
        state_nxt.leftover = data_byte[3:0];
        state_nxt.phase    = PHASE_THIRD;
        if (last_byte) begin
          burst.chars[1] = sextet_char({data_byte[3:0], 2'b00});
          burst.chars[2] = CHAR_PAD;
          burst.cnt      = 3'd3;
        end
      end
      PHASE_THIRD: begin
        // Finish the group and break the line when it is full
        burst.chars[0]     = sextet_char({state_cur.leftover, data_byte[7:6]});
        burst.chars[1]     = sextet_char(data_byte[5:0]);
        burst.cnt          = 3'd2;
        state_nxt.leftover = 4'd0;
        state_nxt.phase    = PHASE_FIRST;
        state_nxt.groups   = groups_inc;
        if (groups_inc >= GROUP_W'(GROUPS_PER_LINE)) begin
          burst.chars[2]   = CHAR_CR;
          burst.chars[3]   = CHAR_LF;
          burst.cnt        = 3'd4;
          state_nxt.groups = '0;
        end
      end
      default: begin
        // First byte of a group; an unused phase code acts the same
        burst.chars[0]     = sextet_char(data_byte[7:2]);
        burst.cnt          = 3'd1;
        state_nxt.leftover = {2'b00, data_byte[1:0]};
        state_nxt.phase    = PHASE_SECOND;
        if (last_byte) begin
          burst.chars[1] = sextet_char({data_byte[1:0], 4'b0000});
          burst.chars[2] = CHAR_PAD;
          burst.chars[3] = CHAR_PAD;
          burst.cnt      = 3'd4;
        end
      end
    endcase
    // End of message: clear the state so the next one starts a new group and line count
    if (last_byte) begin
      state_nxt = '0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/base64_line_wrapped_encoder_unit.sv -----
// Top level of the streaming base64 encoder with CR LF after every full line.
//
//   channel  direction  beat payload                  handshake
//   in_s     in         data_byte[7:0], last_byte     valid/ready
//   out_m    out        out_char[7:0], last_char      valid/ready
//
// A byte beat lands in an input register, is encoded on its way into a burst
// register (up to four characters) and leaves one character per cycle while
// out_m.ready is high. Each byte yields one to four characters; a byte moves on
// to the burst register in the cycle its predecessor's last character leaves.
// rst_n (synchronous) clears the encoder state and both stage valid flags.
// A stalled output holds the burst; the input register then holds one byte.
`timescale 1ns / 1ps
`default_nettype none
module base64_line_wrapped_encoder_unit
  import b64le_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  b64le_in_if.sink      in_s,
  b64le_out_if.source   out_m
);

  logic         in_full_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  b64le_state_t state_r;
  b64le_state_t state_nxt;
  b64le_burst_t enc_burst;
  logic [3:0][7:0] chars_r;
  logic [2:0]   cnt_r;
  logic         last_r;
  logic         take;
  logic         burst_free;
  logic         move;

  // Handshake decisions
  assign take       = out_m.valid && out_m.ready;
  assign burst_free = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_m.ready);
  assign move       = in_full_r && burst_free;
  assign in_s.ready = !in_full_r || move;

  // Hold the accepted byte until the burst register can take its characters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_s.valid && in_s.ready) begin
      in_full_r <= 1'b1;
    end else if (move) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      in_byte_r <= in_s.data_byte;
      in_last_r <= in_s.last_byte;
    end
  end

  b64le_encode u_encode (
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .burst     (enc_burst)
  );

  // Advance the encoder state as a byte moves into the burst register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (move) begin
      state_r <= state_nxt;
    end
  end

  // Load a new burst or shift out the character just delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (move) begin
      cnt_r <= enc_burst.cnt;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      chars_r <= enc_burst.chars;
      last_r  <= enc_burst.last;
    end else if (take) begin
      chars_r <= {8'h00, chars_r[3:1]};
    end
  end

  // Drive the output beat
  assign out_m.valid     = (cnt_r != 3'd0);
  assign out_m.out_char  = chars_r[0];
  assign out_m.last_char = last_r && (cnt_r == 3'd1);

  // A byte never overwrites characters still waiting to leave
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    move |-> ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_m.ready)))
    else $error("burst overwritten before delivery");

  // The burst never claims more than four characters
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4)
    else $error("burst count out of range");

  // The line group count wraps before reaching a full line
  a_groups_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.groups < GROUP_W'(GROUPS_PER_LINE))
    else $error("group count past line length");

  // When the final character leaves, the encoder is back at a message start
  a_clean_end: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_m.last_char) |->
      ((state_r.phase == PHASE_FIRST) && (state_r.leftover == 4'd0) &&
       (state_r.groups == '0)))
    else $error("state not cleared at end of message");

endmodule
`default_nettype wire
